@@ hdl/blsu_pkg.sv @@
// Shared types and constants of the byte-lane load/store unit.
package blsu_pkg;

    localparam int MEM_WORDS = 1024;
    localparam int IDX_W     = $clog2(MEM_WORDS);
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    localparam logic [31:0] BYTE_EXT_MASK = 32'hFFFF_FF00;
    localparam logic [31:0] HALF_EXT_MASK = 32'hFFFF_0000;

    typedef enum logic [2:0] {
        CMD_LB = 3'd0,
        CMD_LH = 3'd1,
        CMD_LW = 3'd2,
        CMD_SB = 3'd3,
        CMD_SH = 3'd4,
        CMD_SW = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_LOAD  = 2'd1,
        KIND_STORE = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        SIZE_BYTE = 2'd0,
        SIZE_HALF = 2'd1,
        SIZE_WORD = 2'd2
    } t_size;

    typedef logic [IDX_W-1:0] t_word_idx;

    typedef struct packed {
        t_kind       kind;
        t_size       size;
        logic        sext;
        logic        err;
        t_word_idx   idx;
        logic [1:0]  lane;
        logic [31:0] value;
    } t_op;

endpackage

@@ hdl/byte_lane_load_store_unit.sv @@
// Top level of the byte-lane load/store unit over a word-organised data memory.
//
// Usage: the block looks like a queue on both sides. An access (command, byte address,
// sign-extend flag and store value) transfers in at a rising edge where push is high and
// full is low. Every access gives exactly one result (read_data, unaligned_error), which
// waits on the result ports while empty is low and transfers out at an edge where pop is
// high. Loads return the addressed byte, halfword or word, zero- or sign-extended from
// the item's own top bit; stores, unused commands and misaligned accesses return zero,
// and a misaligned halfword or word access sets unaligned_error and leaves memory alone.
// A result passes through the queue, the registered memory read and the result register
// before it becomes visible on the result ports.
// Throughput: one access per cycle sustained while pop keeps taking results, set by the
// single memory port that serves one read or one lane-masked write each cycle; a store
// followed by a load of the same word sees the new data because the write lands before the read.
// Reset: i_rst_n is synchronous and active low. After reset a clearing pass zeroes the
// memory one word per cycle across all 1024 words, and full stays high until it is done.
// Stalls: when pop stays low the result register holds, the back end stops issuing,
// the four-entry decode queue fills, and full rises until results drain.
module byte_lane_load_store_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_command,
    input  logic [11:0] i_address,
    input  logic        i_sign_extend,
    input  logic [31:0] i_store_value,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_read_data,
    output logic        o_unaligned_error
);

    // Decoded access from the front end, and the queue head seen by the back end.
    blsu_pkg::t_op w_front_op;
    blsu_pkg::t_op w_head_op;
    logic          w_q_push;
    logic          w_q_full;
    logic          w_q_empty;
    logic          w_q_pop;
    logic          w_clearing;

    // The front end classifies each access and flags misalignment before it is queued.
    blsu_front u_front (
        .i_push        (push),
        .o_full        (full),
        .i_command     (i_command),
        .i_address     (i_address),
        .i_sign_extend (i_sign_extend),
        .i_store_value (i_store_value),
        .i_q_full      (w_q_full),
        .i_clearing    (w_clearing),
        .o_q_push      (w_q_push),
        .o_op          (w_front_op)
    );

    // The queue decouples acceptance from execution so each side can stall on its own.
    blsu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_op    (w_front_op),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_empty (w_q_empty),
        .o_op    (w_head_op)
    );

    // The back end owns the memory, runs the clearing pass and formats the results.
    blsu_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_op_valid        (!w_q_empty),
        .i_op              (w_head_op),
        .o_op_take         (w_q_pop),
        .o_clearing        (w_clearing),
        .o_empty           (empty),
        .i_pop             (pop),
        .o_read_data       (o_read_data),
        .o_unaligned_error (o_unaligned_error)
    );

endmodule

@@ hdl/blsu_front.sv @@
// Front end: decodes and checks an incoming access and pushes it into the queue.
module blsu_front (
    input  logic              i_push,
    output logic              o_full,
    input  logic [2:0]        i_command,
    input  logic [11:0]       i_address,
    input  logic              i_sign_extend,
    input  logic [31:0]       i_store_value,
    input  logic              i_q_full,
    input  logic              i_clearing,
    output logic              o_q_push,
    output blsu_pkg::t_op     o_op
);

    blsu_pkg::t_cmd w_cmd;
    logic           w_misaligned_half;
    logic           w_misaligned_word;

    assign w_cmd             = blsu_pkg::t_cmd'(i_command);
    assign w_misaligned_half = i_address[0];
    assign w_misaligned_word = (i_address[1:0] != 2'b00);

    assign o_full   = i_q_full || i_clearing;
    assign o_q_push = i_push && !o_full;

    always_comb begin
        o_op.sext  = i_sign_extend;
        o_op.idx   = blsu_pkg::t_word_idx'(32'(i_address[11:2]) % blsu_pkg::MEM_WORDS);
        o_op.lane  = i_address[1:0];
        o_op.value = i_store_value;
        o_op.err   = 1'b0;
        o_op.size  = blsu_pkg::SIZE_BYTE;
        o_op.kind  = blsu_pkg::KIND_NONE;
        case (w_cmd) inside
            blsu_pkg::CMD_LB, blsu_pkg::CMD_LH, blsu_pkg::CMD_LW: begin
                o_op.kind = blsu_pkg::KIND_LOAD;
            end
            blsu_pkg::CMD_SB, blsu_pkg::CMD_SH, blsu_pkg::CMD_SW: begin
                o_op.kind = blsu_pkg::KIND_STORE;
            end
            default: begin
                o_op.kind = blsu_pkg::KIND_NONE;
            end
        endcase
        case (w_cmd)
            blsu_pkg::CMD_LH, blsu_pkg::CMD_SH: begin
                o_op.size = blsu_pkg::SIZE_HALF;
                o_op.err  = w_misaligned_half;
            end
            blsu_pkg::CMD_LW, blsu_pkg::CMD_SW: begin
                o_op.size = blsu_pkg::SIZE_WORD;
                o_op.err  = w_misaligned_word;
            end
            default: begin
                o_op.size = blsu_pkg::SIZE_BYTE;
            end
        endcase
    end

endmodule

@@ hdl/blsu_queue.sv @@
// Short queue of decoded accesses between the front end and the memory back end.
module blsu_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  blsu_pkg::t_op i_op,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output blsu_pkg::t_op o_op
);

    blsu_pkg::t_op                r_slot [blsu_pkg::Q_DEPTH];
    logic [blsu_pkg::Q_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [blsu_pkg::Q_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [blsu_pkg::Q_CNT_W-1:0] r_cnt, n_cnt;
    logic                         w_push;
    logic                         w_pop;

    assign o_full  = (r_cnt == blsu_pkg::Q_CNT_W'(blsu_pkg::Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_op    = r_slot[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = w_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = w_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_cnt    = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_op;
        end
    end

endmodule

@@ hdl/blsu_back.sv @@
// Back end: data memory with byte-lane writes, load formatting and the result register.
module blsu_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_op_valid,
    input  blsu_pkg::t_op i_op,
    output logic          o_op_take,
    output logic          o_clearing,
    output logic          o_empty,
    input  logic          i_pop,
    output logic [31:0]   o_read_data,
    output logic          o_unaligned_error
);

    logic [3:0][7:0]       r_mem [blsu_pkg::MEM_WORDS];
    logic [31:0]           r_rdata;

    logic                  r_clr_busy;
    blsu_pkg::t_word_idx   r_clr_idx;

    logic                  r_s1_valid;
    blsu_pkg::t_kind       r_s1_kind;
    blsu_pkg::t_size       r_s1_size;
    logic                  r_s1_sext;
    logic                  r_s1_err;
    logic [1:0]            r_s1_lane;

    logic                  r_out_valid;
    logic [31:0]           r_out_data;
    logic                  r_out_err;

    logic                  w_pop_ok;
    logic                  w_s1_adv;
    logic                  w_issue;
    logic                  w_we;
    logic                  w_re;
    logic [3:0]            w_be;
    logic [31:0]           w_wdata;
    blsu_pkg::t_word_idx   w_widx;
    logic [31:0]           w_shifted;
    logic [31:0]           w_fmt;

    assign w_pop_ok   = i_pop && r_out_valid;
    assign w_s1_adv   = r_s1_valid && (!r_out_valid || w_pop_ok);
    assign w_issue    = !r_clr_busy && i_op_valid && (!r_s1_valid || w_s1_adv);
    assign o_op_take  = w_issue;
    assign o_clearing = r_clr_busy;

    assign w_re = w_issue && (i_op.kind == blsu_pkg::KIND_LOAD) && !i_op.err;
    assign w_we = r_clr_busy
               || (w_issue && (i_op.kind == blsu_pkg::KIND_STORE) && !i_op.err);

    // Lane enables and replicated store data; the clearing pass writes zeros everywhere.
    always_comb begin
        w_widx  = i_op.idx;
        w_be    = 4'b0001 << i_op.lane;
        w_wdata = {4{i_op.value[7:0]}};
        case (i_op.size)
            blsu_pkg::SIZE_HALF: begin
                w_be    = i_op.lane[1] ? 4'b1100 : 4'b0011;
                w_wdata = {2{i_op.value[15:0]}};
            end
            blsu_pkg::SIZE_WORD: begin
                w_be    = 4'b1111;
                w_wdata = i_op.value;
            end
            default: begin
                w_be    = 4'b0001 << i_op.lane;
                w_wdata = {4{i_op.value[7:0]}};
            end
        endcase
        if (r_clr_busy) begin
            w_widx  = r_clr_idx;
            w_be    = 4'b1111;
            w_wdata = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            for (int b = 0; b < 4; b++) begin
                if (w_be[b]) begin
                    r_mem[w_widx][b] <= w_wdata[8*b +: 8];
                end
            end
        end
        if (w_re) begin
            r_rdata <= r_mem[i_op.idx];
        end
    end

    // Load formatting from the registered read word.
    always_comb begin
        w_shifted = r_rdata >> {r_s1_lane, 3'b000};
        w_fmt     = '0;
        if ((r_s1_kind == blsu_pkg::KIND_LOAD) && !r_s1_err) begin
            case (r_s1_size)
                blsu_pkg::SIZE_HALF: begin
                    w_fmt = {16'h0000, w_shifted[15:0]};
                    if (r_s1_sext && w_shifted[15]) begin
                        w_fmt = w_fmt | blsu_pkg::HALF_EXT_MASK;
                    end
                end
                blsu_pkg::SIZE_WORD: begin
                    w_fmt = r_rdata;
                end
                default: begin
                    w_fmt = {24'h000000, w_shifted[7:0]};
                    if (r_s1_sext && w_shifted[7]) begin
                        w_fmt = w_fmt | blsu_pkg::BYTE_EXT_MASK;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_idx   <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_idx <= r_clr_idx + 1'b1;
                if (r_clr_idx == blsu_pkg::t_word_idx'(blsu_pkg::MEM_WORDS - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (w_issue) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (w_pop_ok) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_s1_kind <= i_op.kind;
            r_s1_size <= i_op.size;
            r_s1_sext <= i_op.sext;
            r_s1_err  <= i_op.err;
            r_s1_lane <= i_op.lane;
        end
        if (w_s1_adv) begin
            r_out_data <= w_fmt;
            r_out_err  <= r_s1_err;
        end
    end

    assign o_empty           = !r_out_valid;
    assign o_read_data       = r_out_data;
    assign o_unaligned_error = r_out_err;

    a_no_issue_while_clearing: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) r_clr_busy |-> !w_issue
    ) else $error("access issued during the memory clearing pass");

    a_error_result_is_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_err) |-> (r_out_data == '0)
    ) else $error("misaligned access returned nonzero data");

    a_faulty_op_never_writes: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_issue && i_op.err) |-> !w_we
    ) else $error("misaligned store wrote memory");

    a_held_result_stays: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_pop) |=> (r_out_valid && $stable(r_out_data) && $stable(r_out_err))
    ) else $error("waiting result changed before transfer");

endmodule
